// File: hw/rtl/dcm_pkg.sv
// Shared types and constants for the delta change-mask record encoder.
// No dependencies; all files but dcm_channels use it by scoped names.
`timescale 1ns / 1ps

package dcm_pkg;

    localparam int REC_BYTES = 24;
    localparam int LEN_W     = 5;

    localparam logic [LEN_W-1:0] ABS_LEN        = 5'd24;
    localparam logic [LEN_W-1:0] DELTA_BASE_LEN = 5'd2;

    // change-mask bit positions
    localparam int MB_NSEC  = 0;
    localparam int MB_PSEC  = 1;
    localparam int MB_X     = 2;
    localparam int MB_Y     = 3;
    localparam int MB_Z     = 4;
    localparam int MB_ROLL  = 5;
    localparam int MB_HEAD  = 6;
    localparam int MB_PITCH = 7;

    localparam int WIDE_FIELDS = 6;

    typedef struct packed {
        logic [15:0] cmd;
        logic [15:0] hdg;
        logic [15:0] pit;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } prev_t;

    typedef struct packed {
        logic [15:0] cmd;
        logic [15:0] hdg;
        logic [15:0] pit;
        logic [15:0] rol;
        logic [15:0] nsec;
        logic [15:0] psec;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } fields_t;

    typedef struct packed {
        logic [LEN_W-1:0]               len;
        logic [REC_BYTES-1:0][7:0]      bytes;
    } record_t;

endpackage

// File: hw/rtl/dcm_channels.sv
// Channel interfaces of the delta change-mask record encoder: input items,
// output bytes and the configuration write channel. No dependencies.
`timescale 1ns / 1ps

interface dcm_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         entity_index;
    logic signed [15:0] command;
    logic signed [15:0] heading;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] near_section;
    logic signed [15:0] prev_section;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (
        output valid, action, entity_index, command, heading, pitch_angle, roll_angle,
               near_section, prev_section, pos_x, pos_y, pos_z,
        input  ready
    );
    modport sink (
        input  valid, action, entity_index, command, heading, pitch_angle, roll_angle,
               near_section, prev_section, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

interface dcm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    logic [4:0] record_length;

    modport source (output valid, out_byte, last_byte, record_length, input ready);
    modport sink (input valid, out_byte, last_byte, record_length, output ready);
endinterface

interface dcm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] remote_entity;

    modport source (output valid, remote_entity, input ready);
    modport sink (input valid, remote_entity, output ready);
endinterface

// File: hw/rtl/dcm_front.sv
// Front end: accepts items, filters them, looks up per-entity history and
// builds the absolute or delta record. Depends on dcm_pkg and dcm_channels.
`timescale 1ns / 1ps

module dcm_front #(
    parameter int NUM_ENTITIES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    dcm_in_if.sink            item,
    input  logic [2:0]        remote_entity,
    output logic              rec_valid,
    input  logic              rec_ready,
    output dcm_pkg::record_t  rec
);

    localparam int IDX_W = $clog2(NUM_ENTITIES);

    logic                    accept;
    logic                    keep;
    logic [IDX_W-1:0]        idx;
    dcm_pkg::fields_t        cur;

    logic                    delta_mode_reg;
    logic                    delta_mode_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_mode_reg;
    logic [NUM_ENTITIES-1:0] ent_vld_reg;
    logic                    s1_prev_vld_reg;
    dcm_pkg::prev_t          mem [NUM_ENTITIES];
    dcm_pkg::prev_t          s1_prev_reg;
    dcm_pkg::fields_t        s1_cur_reg;

    dcm_pkg::prev_t          prev;
    logic [7:0]              mask;
    logic [7:0]              cmd_d;
    logic [7:0]              hdg_d;
    logic [7:0]              pit_d;
    logic [dcm_pkg::WIDE_FIELDS-1:0][15:0] wide;
    logic [dcm_pkg::LEN_W-1:0] pos;

    assign item.ready = !s1_valid_reg || rec_ready;
    assign accept     = item.valid && item.ready;
    assign keep       = accept && !item.action && (item.entity_index != remote_entity)
                        && (32'(item.entity_index) < NUM_ENTITIES);
    assign idx        = IDX_W'(item.entity_index);

    assign cur = '{cmd: item.command, hdg: item.heading, pit: item.pitch_angle,
                   rol: item.roll_angle, nsec: item.near_section,
                   psec: item.prev_section, x: item.pos_x, y: item.pos_y,
                   z: item.pos_z};

    always_comb
    begin
        delta_mode_next = delta_mode_reg;
        if (accept && item.action)
        begin
            delta_mode_next = 1'b1;
        end
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = keep;
        end
        else if (rec_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_mode_reg  <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_mode_reg     <= 1'b0;
            ent_vld_reg     <= '0;
            s1_prev_vld_reg <= 1'b0;
        end
        else
        begin
            delta_mode_reg <= delta_mode_next;
            s1_valid_reg   <= s1_valid_next;
            if (keep)
            begin
                s1_mode_reg      <= delta_mode_reg;
                s1_prev_vld_reg  <= ent_vld_reg[idx];
                ent_vld_reg[idx] <= 1'b1;
            end
        end
    end

    // history memory: read old entry and write the new one at the same edge
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            mem[idx]    <= '{cmd: cur.cmd, hdg: cur.hdg, pit: cur.pit,
                             x: cur.x, y: cur.y, z: cur.z};
            s1_prev_reg <= mem[idx];
            s1_cur_reg  <= cur;
        end
    end

    always_comb
    begin
        prev  = s1_prev_vld_reg ? s1_prev_reg : '0;
        mask[dcm_pkg::MB_NSEC]  = (s1_cur_reg.nsec != 16'd0);
        mask[dcm_pkg::MB_PSEC]  = (s1_cur_reg.psec != 16'd0);
        mask[dcm_pkg::MB_X]     = (s1_cur_reg.x != prev.x);
        mask[dcm_pkg::MB_Y]     = (s1_cur_reg.y != prev.y);
        mask[dcm_pkg::MB_Z]     = (s1_cur_reg.z != prev.z);
        mask[dcm_pkg::MB_ROLL]  = (s1_cur_reg.rol != 16'd0);
        mask[dcm_pkg::MB_HEAD]  = (s1_cur_reg.hdg != prev.hdg);
        mask[dcm_pkg::MB_PITCH] = (s1_cur_reg.pit != prev.pit);

        cmd_d = s1_cur_reg.cmd[7:0] - prev.cmd[7:0];
        hdg_d = s1_cur_reg.hdg[7:0] - prev.hdg[7:0];
        pit_d = s1_cur_reg.pit[7:0] - prev.pit[7:0];

        wide[dcm_pkg::MB_NSEC] = s1_cur_reg.nsec;
        wide[dcm_pkg::MB_PSEC] = s1_cur_reg.psec;
        wide[dcm_pkg::MB_X]    = s1_cur_reg.x[15:0] - prev.x[15:0];
        wide[dcm_pkg::MB_Y]    = s1_cur_reg.y[15:0] - prev.y[15:0];
        wide[dcm_pkg::MB_Z]    = s1_cur_reg.z[15:0] - prev.z[15:0];
        wide[dcm_pkg::MB_ROLL] = s1_cur_reg.rol;

        rec.bytes = '0;
        pos       = dcm_pkg::DELTA_BASE_LEN;
        if (!s1_mode_reg)
        begin
            rec.bytes = {s1_cur_reg.z, s1_cur_reg.y, s1_cur_reg.x, s1_cur_reg.psec,
                         s1_cur_reg.nsec, s1_cur_reg.rol, s1_cur_reg.pit,
                         s1_cur_reg.hdg, s1_cur_reg.cmd};
            rec.len   = dcm_pkg::ABS_LEN;
        end
        else
        begin
            rec.bytes[0] = mask;
            rec.bytes[1] = cmd_d;
            for (int i = 0; i < dcm_pkg::WIDE_FIELDS; i++)
            begin
                if (mask[i])
                begin
                    rec.bytes[pos]        = wide[i][7:0];
                    rec.bytes[pos + 5'd1] = wide[i][15:8];
                    pos                   = pos + 5'd2;
                end
            end
            if (mask[dcm_pkg::MB_HEAD])
            begin
                rec.bytes[pos] = hdg_d;
                pos            = pos + 5'd1;
            end
            if (mask[dcm_pkg::MB_PITCH])
            begin
                rec.bytes[pos] = pit_d;
                pos            = pos + 5'd1;
            end
            rec.len = pos;
        end
    end

    assign rec_valid = s1_valid_reg;

endmodule

// File: hw/rtl/dcm_queue.sv
// Short record queue between front and back end.
// Depends on dcm_pkg.
`timescale 1ns / 1ps

module dcm_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dcm_pkg::record_t  in_rec,
    output logic              out_valid,
    input  logic              out_ready,
    output dcm_pkg::record_t  out_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dcm_pkg::record_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               push;
    logic               pop;

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_rec   = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_rec;
        end
    end

endmodule

// File: hw/rtl/dcm_back.sv
// Back end: holds one record and sends it one byte per cycle while result.ready is high.
// Depends on dcm_pkg and dcm_channels.
`timescale 1ns / 1ps

module dcm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    output logic              rec_ready,
    input  dcm_pkg::record_t  rec,
    dcm_out_if.source         result
);

    dcm_pkg::record_t          rec_reg;
    logic [dcm_pkg::LEN_W-1:0] ptr_reg;
    logic [dcm_pkg::LEN_W-1:0] ptr_next;
    logic                      busy_reg;
    logic                      busy_next;
    logic                      take;
    logic                      last;
    logic                      load;

    assign last      = (ptr_reg + 5'd1 == rec_reg.len);
    assign take      = busy_reg && result.ready;
    assign rec_ready = !busy_reg || (take && last);
    assign load      = rec_valid && rec_ready;

    assign result.valid         = busy_reg;
    assign result.out_byte      = rec_reg.bytes[ptr_reg];
    assign result.last_byte     = last;
    assign result.record_length = rec_reg.len;

    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (load)
        begin
            busy_next = 1'b1;
            ptr_next  = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            ptr_next = ptr_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ptr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec;
        end
    end

endmodule

// File: hw/rtl/delta_change_mask_record_encoder.sv
// Top level of the delta change-mask record encoder: configuration register,
// front end, record queue and byte serializer. Depends on dcm_pkg, dcm_channels,
// dcm_front, dcm_queue and dcm_back.
//
// Usage:
//   item   : one entity record or end-of-frame mark per handshake.
//   result : one byte per handshake, with last_byte and record_length.
//   cfg    : writes remote_entity; always ready, write only while idle.
// Records stream out one byte per cycle while result.ready is high: absolute records
// have 24 bytes, delta records 2 to 16; the byte serializer sets the sustained rate.
// Items are accepted one per cycle while the two-entry record queue has room;
// end-of-frame marks and dropped records never occupy it.
// With the block empty, an accepted item's record passes the front stage register,
// the record queue and the serializer's record register before its first byte shows.
// Reset returns to absolute mode, clears remote_entity and marks all
// entity history as zero at once; no clearing pass is needed.
// A stalled receiver holds the current byte; the queue then fills and
// item.ready falls.
`timescale 1ns / 1ps

module delta_change_mask_record_encoder #(
    parameter int NUM_ENTITIES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    dcm_in_if.sink    item,
    dcm_out_if.source result,
    dcm_cfg_if.sink   cfg
);

    logic [2:0]        remote_reg;
    logic              f_valid;
    logic              f_ready;
    dcm_pkg::record_t  f_rec;
    logic              q_valid;
    logic              q_ready;
    dcm_pkg::record_t  q_rec;
    logic              first_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_reg <= '0;
            first_reg  <= 1'b1;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                remote_reg <= cfg.remote_entity;
            end
            if (result.valid && result.ready)
            begin
                first_reg <= result.last_byte;
            end
        end
    end

    dcm_front #(
        .NUM_ENTITIES (NUM_ENTITIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .remote_entity (remote_reg),
        .rec_valid     (f_valid),
        .rec_ready     (f_ready),
        .rec           (f_rec)
    );

    dcm_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rec    (f_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    dcm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .rec       (q_rec),
        .result    (result)
    );

    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.record_length == dcm_pkg::ABS_LEN)
            || ((result.record_length >= 5'd2) && (result.record_length <= 5'd16)))
        else $error("record length out of range");

    a_bytes_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !result.last_byte)
            |=> (result.valid && (result.record_length == $past(result.record_length))))
        else $error("gap inside a record");

    a_mask_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && first_reg && (result.record_length != dcm_pkg::ABS_LEN))
            |-> (32'(result.record_length) == 2 + 2 * $countones(result.out_byte[5:0])
                 + $countones(result.out_byte[7:6])))
        else $error("delta length disagrees with change mask");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the delta change-mask record encoder: directed records, then
// random record streams under random stalls, checked byte by byte against a local encoder.
// Depends on dcm_pkg, dcm_channels and delta_change_mask_record_encoder.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_ENT     = 8;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int PER_PHASE   = 70;

    typedef struct packed {
        logic             eof;
        logic [2:0]       ent;
        logic             typed;
        logic [4:0]       n;
        logic [7:0]       fill;
        dcm_pkg::fields_t f;
    } plan_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [4:0] len;
    } out_byte_t;

    logic clk;
    logic rst_n;

    dcm_in_if  item_ch ();
    dcm_out_if result_ch ();
    dcm_cfg_if cfg_ch ();

    delta_change_mask_record_encoder #(
        .NUM_ENTITIES(NUM_ENT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic        delta_mode;
    logic [2:0]  partner;
    logic [15:0] seen_cmd [NUM_ENT];
    logic [15:0] seen_hdg [NUM_ENT];
    logic [15:0] seen_pit [NUM_ENT];
    logic [31:0] seen_x [NUM_ENT];
    logic [31:0] seen_y [NUM_ENT];
    logic [31:0] seen_z [NUM_ENT];

    out_byte_t bytes_due [$];
    plan_row_t plan [19];
    int        errors;
    int        send_gap;
    int        drain_gap;
    bit        hold_out;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 100)
            $display("%0t mismatch: %s", $time, what);
    endtask

    function automatic plan_row_t row(input logic eof, input logic [2:0] ent,
                                      input logic typed, input logic [4:0] n,
                                      input logic [7:0] fill,
                                      input logic [15:0] cmd, hdg, pit, rol, nsec, psec,
                                      input logic [31:0] x, y, z);
        row = '{eof: eof, ent: ent, typed: typed, n: n, fill: fill,
                f: '{cmd, hdg, pit, rol, nsec, psec, x, y, z}};
    endfunction

    function automatic logic [15:0] near16(input logic [15:0] base);
        case ($urandom_range(0, 7))
            0, 1, 2: return base;
            3: return base + 16'($urandom_range(0, 510)) - 16'd255;
            4: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            5: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] near32(input logic [31:0] base);
        case ($urandom_range(0, 7))
            0, 1, 2: return base;
            3: return base + 32'($urandom_range(0, 131070)) - 32'd65535;
            4: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            5: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void encode_record(input logic eof, input logic [2:0] ent,
                                          input dcm_pkg::fields_t f,
                                          output logic [7:0] rec [$]);
        logic [7:0]  mask;
        logic [15:0] wide [dcm_pkg::WIDE_FIELDS];
        logic [15:0] narrow [6];
        logic [31:0] pos [3];
        rec = {};
        if (eof)
        begin
            delta_mode = 1'b1;
            return;
        end
        if (ent == partner || int'(ent) >= NUM_ENT)
            return;
        if (!delta_mode)
        begin
            narrow = '{f.cmd, f.hdg, f.pit, f.rol, f.nsec, f.psec};
            pos = '{f.x, f.y, f.z};
            foreach (narrow[i])
            begin
                rec.push_back(narrow[i][7:0]);
                rec.push_back(narrow[i][15:8]);
            end
            foreach (pos[i])
                for (int b = 0; b < 4; b++)
                    rec.push_back(pos[i][8*b +: 8]);
        end
        else
        begin
            mask = '0;
            mask[dcm_pkg::MB_NSEC]  = (f.nsec != 16'h0);
            mask[dcm_pkg::MB_PSEC]  = (f.psec != 16'h0);
            mask[dcm_pkg::MB_X]     = (f.x != seen_x[ent]);
            mask[dcm_pkg::MB_Y]     = (f.y != seen_y[ent]);
            mask[dcm_pkg::MB_Z]     = (f.z != seen_z[ent]);
            mask[dcm_pkg::MB_ROLL]  = (f.rol != 16'h0);
            mask[dcm_pkg::MB_HEAD]  = (f.hdg != seen_hdg[ent]);
            mask[dcm_pkg::MB_PITCH] = (f.pit != seen_pit[ent]);
            wide[dcm_pkg::MB_NSEC] = f.nsec;
            wide[dcm_pkg::MB_PSEC] = f.psec;
            wide[dcm_pkg::MB_X]    = 16'(f.x - seen_x[ent]);
            wide[dcm_pkg::MB_Y]    = 16'(f.y - seen_y[ent]);
            wide[dcm_pkg::MB_Z]    = 16'(f.z - seen_z[ent]);
            wide[dcm_pkg::MB_ROLL] = f.rol;
            rec.push_back(mask);
            rec.push_back(8'(f.cmd - seen_cmd[ent]));
            for (int b = 0; b < dcm_pkg::WIDE_FIELDS; b++)
            begin
                if (mask[b])
                begin
                    rec.push_back(wide[b][7:0]);
                    rec.push_back(wide[b][15:8]);
                end
            end
            if (mask[dcm_pkg::MB_HEAD])
                rec.push_back(8'(f.hdg - seen_hdg[ent]));
            if (mask[dcm_pkg::MB_PITCH])
                rec.push_back(8'(f.pit - seen_pit[ent]));
        end
        seen_cmd[ent] = f.cmd;
        seen_hdg[ent] = f.hdg;
        seen_pit[ent] = f.pit;
        seen_x[ent]   = f.x;
        seen_y[ent]   = f.y;
        seen_z[ent]   = f.z;
    endfunction

    task automatic offer(input logic eof, input logic [2:0] ent, input dcm_pkg::fields_t f,
                         input logic typed, input logic [4:0] typed_n,
                         input logic [7:0] typed_fill, output int produced);
        int         gap;
        logic [7:0] rec [$];
        gap = $urandom_range(0, send_gap);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= eof;
        item_ch.entity_index <= ent;
        item_ch.command      <= f.cmd;
        item_ch.heading      <= f.hdg;
        item_ch.pitch_angle  <= f.pit;
        item_ch.roll_angle   <= f.rol;
        item_ch.near_section <= f.nsec;
        item_ch.prev_section <= f.psec;
        item_ch.pos_x        <= f.x;
        item_ch.pos_y        <= f.y;
        item_ch.pos_z        <= f.z;
        do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
        encode_record(eof, ent, f, rec);
        if (typed)
        begin
            rec = {};
            repeat (typed_n) rec.push_back(typed_fill);
        end
        foreach (rec[k])
            bytes_due.push_back('{rec[k], (k == rec.size() - 1), 5'(rec.size())});
        produced = rec.size();
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_partner(input logic [2:0] idx);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.remote_entity <= idx;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        partner = idx;
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold on request
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                gap = HOLD_CYCLES;
                hold_out = 1'b0;
            end
            else
                gap = $urandom_range(0, drain_gap);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    always @(posedge clk)
    begin
        out_byte_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (bytes_due.size() == 0)
                report($sformatf("unexpected byte %h", result_ch.out_byte));
            else
            begin
                want = bytes_due.pop_front();
                if (result_ch.out_byte !== want.data)
                    report($sformatf("out_byte %h, want %h", result_ch.out_byte, want.data));
                if (result_ch.last_byte !== want.last)
                    report($sformatf("last_byte %b, want %b", result_ch.last_byte, want.last));
                if (result_ch.record_length !== want.len)
                    report($sformatf("record_length %0d, want %0d",
                                     result_ch.record_length, want.len));
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int               made;
        int               n;
        bit               paused;
        logic             eof;
        logic [2:0]       ent;
        dcm_pkg::fields_t f;
        logic [2:0]       partner_plan [4];
        int               send_plan [4];
        int               drain_plan [4];

        partner_plan = '{3'd7, 3'd3, 3'd0, 3'd5};
        send_plan    = '{18, 0, 18, 0};
        drain_plan   = '{18, 0, 18, 18};
        errors     = 0;
        delta_mode = 1'b0;
        partner    = 3'd0;
        hold_out   = 1'b0;
        send_gap   = 18;
        drain_gap  = 18;
        foreach (seen_cmd[i])
        begin
            seen_cmd[i] = '0;
            seen_hdg[i] = '0;
            seen_pit[i] = '0;
            seen_x[i]   = '0;
            seen_y[i]   = '0;
            seen_z[i]   = '0;
        end

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.action       <= 1'b0;
        item_ch.entity_index <= '0;
        item_ch.command      <= '0;
        item_ch.heading      <= '0;
        item_ch.pitch_angle  <= '0;
        item_ch.roll_angle   <= '0;
        item_ch.near_section <= '0;
        item_ch.prev_section <= '0;
        item_ch.pos_x        <= '0;
        item_ch.pos_y        <= '0;
        item_ch.pos_z        <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.remote_entity <= '0;

        plan = '{
            row(0, 3'd0, 1, 5'd0, 8'h00, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
                16'h1234, 32'h12345678, 32'h12345678, 32'h12345678),
            row(0, 3'd1, 1, 5'd24, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 32'h00000000, 32'h00000000, 32'h00000000),
            row(0, 3'd2, 1, 5'd24, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
            row(0, 3'd3, 0, 5'd0, 8'h00, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                16'h7FFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000001),
            row(0, 3'd4, 0, 5'd0, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h0011,
                16'h0000, 32'h12345678, 32'h9ABCDEF0, 32'h0FEDCBA9),
            row(0, 3'd7, 0, 5'd0, 8'h00, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h4000, 16'h0000,
                16'h2222, 32'hFFFFFFFE, 32'h00000002, 32'h80000000),
            row(1, 3'd5, 1, 5'd0, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
            row(1, 3'd0, 1, 5'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 32'h00000000, 32'h00000000, 32'h00000000),
            row(0, 3'd1, 1, 5'd2, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 32'h00000000, 32'h00000000, 32'h00000000),
            row(0, 3'd2, 1, 5'd2, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
            row(0, 3'd2, 0, 5'd0, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF),
            row(0, 3'd3, 0, 5'd0, 8'h00, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                16'h8000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF),
            row(0, 3'd5, 0, 5'd0, 8'h00, 16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505,
                16'h0606, 32'h01010101, 32'h02020202, 32'h03030303),
            row(0, 3'd4, 0, 5'd0, 8'h00, 16'h1234, 16'h5678, 16'h9ABC, 16'h0000, 16'h0011,
                16'h0000, 32'h12345679, 32'h9ABCDEF0, 32'h0FEDCBA9),
            row(0, 3'd6, 0, 5'd0, 8'h00, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 32'h00000000, 32'h00000000, 32'h00000000),
            row(0, 3'd6, 0, 5'd0, 8'h00, 16'h0000, 16'h0100, 16'h0001, 16'h0000, 16'h0000,
                16'h0000, 32'h00010000, 32'h00000000, 32'h00000000),
            row(0, 3'd0, 1, 5'd0, 8'h00, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555,
                16'h5555, 32'h55555555, 32'h55555555, 32'h55555555),
            row(0, 3'd7, 0, 5'd0, 8'h00, 16'h8000, 16'h0001, 16'hFFFE, 16'h4000, 16'h0000,
                16'h2222, 32'hFFFFFFFE, 32'h00000002, 32'h80000000),
            row(0, 3'd1, 0, 5'd0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                16'h0000, 32'h00000000, 32'h00000001, 32'hFFFF0000)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_partner(3'd0);

        foreach (plan[i])
            offer(plan[i].eof, plan[i].ent, plan[i].f, plan[i].typed, plan[i].n,
                  plan[i].fill, n);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            send_gap  = send_plan[p];
            drain_gap = drain_plan[p];
            set_partner(partner_plan[p]);
            // stall the result side long enough to back up the record queue
            if (p == 1)
                hold_out = 1'b1;
            made   = 0;
            paused = 1'b0;
            while (made < PER_PHASE)
            begin
                if (p == 2 && made == PER_PHASE / 2 && !paused)
                begin
                    drain();
                    paused = 1'b1;
                end
                eof = ($urandom_range(0, 39) == 0);
                ent = 3'($urandom_range(0, NUM_ENT - 1));
                f.cmd  = near16(seen_cmd[ent]);
                f.hdg  = near16(seen_hdg[ent]);
                f.pit  = near16(seen_pit[ent]);
                f.rol  = near16(16'h0000);
                f.nsec = near16(16'h0000);
                f.psec = near16(16'h0000);
                f.x    = near32(seen_x[ent]);
                f.y    = near32(seen_y[ent]);
                f.z    = near32(seen_z[ent]);
                offer(eof, ent, f, 1'b0, 5'd0, 8'h00, n);
                if (n > 0)
                    made++;
            end
            drain();
        end

        if (errors == 0 && bytes_due.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dcm_pkg.sv
hw/rtl/dcm_channels.sv
hw/rtl/dcm_front.sv
hw/rtl/dcm_queue.sv
hw/rtl/dcm_back.sv
hw/rtl/delta_change_mask_record_encoder.sv
bench/testbench.sv
